// ----- rtl/rdc_pkg.sv -----
package rdc_pkg;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        left_index;
    logic [INDEX_W-1:0]        right_index;
  } rdc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_count;
    logic [1:0]         status;
  } rdc_out_t;

endpackage

// ----- rtl/rdc_ram.sv -----
module rdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/range_distinct_count_top.sv -----
// channel | ports                         | moves
// in      | in_valid, in_stall, in_data   | one command word: clear, load or query
// out     | out_valid, out_stall, out_data | one result word: count and status
//
// clear, a refused load, a query error and left above right go straight to the response
// a load scans back from the newest entry and stops once an equal entry turns up
// a query scans every entry of its span
// both scans run on the single read port of the scanned ram, one entry a cycle
// rst_n is synchronous, active low; it empties the store, ram contents are left
// a stalled result word waits in the output register; the next command word is
// taken once the sequencer is back in idle
module range_distinct_count_top #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rdc_pkg::rdc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rdc_pkg::rdc_out_t out_data
);

  import rdc_pkg::*;

  // address, fill count and scan pointer widths
  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned LCW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (LCW > INDEX_W) ? LCW : INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_QUERY = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LCW-1:0]      loaded_count_r, loaded_count_nxt;
  logic [CMPW-1:0]     scan_ptr_r, scan_ptr_nxt;
  logic                more_r, more_nxt;      // reads still to issue
  logic                rd_pend_r, rd_pend_nxt; // ram data arrives this cycle
  logic [AW-1:0]       rd_q_addr_r, rd_q_addr_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [CMPW-1:0]     lo_r, lo_nxt;
  logic [CMPW-1:0]     hi_r, hi_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  rdc_out_t            res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  rdc_out_t            out_data_r, out_data_nxt;

  // ram ports
  logic                rd_en;
  logic                wr_en;
  logic [AW:0]         prev_wr_data;
  logic [VALUE_W-1:0]  val_rd_data;
  logic [AW:0]         prev_rd_data;

  // shared step unit: one adder and one end compare for both scans
  logic [CMPW-1:0]     step_sum;
  logic                step_last;
  logic                hit;
  logic                repeat_pos;
  logic [CMPW-1:0]     right_ext;
  logic [CMPW-1:0]     left_ext;
  logic [CMPW-1:0]     loaded_ext;

  assign right_ext  = CMPW'(in_data.right_index);
  assign left_ext   = CMPW'(in_data.left_index);
  assign loaded_ext = CMPW'(loaded_count_r);

  assign step_sum  = scan_ptr_r + ((state_r == S_LOAD) ? {CMPW{1'b1}} : CMPW'(1));
  assign step_last = (scan_ptr_r == ((state_r == S_LOAD) ? '0 : hi_r));

  assign hit        = rd_pend_r && (val_rd_data == val_r);
  assign repeat_pos = prev_rd_data[AW] && (CMPW'(prev_rd_data[AW-1:0]) >= lo_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt        = state_r;
    loaded_count_nxt = loaded_count_r;
    scan_ptr_nxt     = scan_ptr_r;
    more_nxt         = more_r;
    rd_pend_nxt      = 1'b0;
    rd_q_addr_nxt    = rd_q_addr_r;
    val_nxt          = val_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    count_nxt        = count_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    prev_wr_data     = {hit, hit ? rd_q_addr_r : AW'(0)};

    unique case (state_r)
      S_IDLE: begin
        res_nxt = '{distinct_count: '0, status: ST_OK};
        if (in_valid) begin
          val_nxt   = in_data.value;
          lo_nxt    = left_ext;
          hi_nxt    = right_ext;
          count_nxt = '0;
          state_nxt = S_RESP;
          case (in_data.action)
            ACT_CLEAR: begin
              loaded_count_nxt = '0;
            end
            ACT_LOAD: begin
              if (loaded_count_r == LCW'(STORE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                // scan downwards from the newest entry
                scan_ptr_nxt = loaded_ext - CMPW'(1);
                more_nxt     = (loaded_count_r != '0);
                state_nxt    = S_LOAD;
              end
            end
            ACT_QUERY: begin
              if (right_ext >= loaded_ext) begin
                res_nxt.status = ST_RANGE;
              end else if (left_ext <= right_ext) begin
                scan_ptr_nxt = left_ext;
                more_nxt     = 1'b1;
                state_nxt    = S_QUERY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LOAD: begin
        if (hit || (!rd_pend_r && !more_r)) begin
          // nearest equal entry found, or none at all
          wr_en            = 1'b1;
          loaded_count_nxt = loaded_count_r + LCW'(1);
          more_nxt         = 1'b0;
          state_nxt        = S_RESP;
        end else if (more_r) begin
          rd_en         = 1'b1;
          rd_pend_nxt   = 1'b1;
          rd_q_addr_nxt = scan_ptr_r[AW-1:0];
          scan_ptr_nxt  = step_sum;
          more_nxt      = !step_last;
        end
      end

      S_QUERY: begin
        if (rd_pend_r && !repeat_pos) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (!rd_pend_r && !more_r) begin
          res_nxt.distinct_count = count_r;
          state_nxt              = S_RESP;
        end else if (more_r) begin
          rd_en         = 1'b1;
          rd_pend_nxt   = 1'b1;
          rd_q_addr_nxt = scan_ptr_r[AW-1:0];
          scan_ptr_nxt  = step_sum;
          more_nxt      = !step_last;
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      loaded_count_r <= '0;
      more_r         <= 1'b0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      loaded_count_r <= loaded_count_nxt;
      more_r         <= more_nxt;
      rd_pend_r      <= rd_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    rd_q_addr_r <= rd_q_addr_nxt;
    val_r       <= val_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    count_r     <= count_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // stored values
  rdc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded_count_r[AW-1:0]),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (scan_ptr_r[AW-1:0]),
    .rd_data (val_rd_data)
  );

  // previous equal position, valid flag on top
  rdc_ram #(
    .WIDTH (AW + 1),
    .DEPTH (STORE_DEPTH)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded_count_r[AW-1:0]),
    .wr_data (prev_wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_ptr_r[AW-1:0]),
    .rd_data (prev_rd_data)
  );

  // fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_count_r <= LCW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  // a write only happens while loading into a store with room left
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_LOAD) && (loaded_count_r < LCW'(STORE_DEPTH)))
    else $error("store written without room");

  // each write grows the fill count by one
  a_write_grow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> loaded_count_r == $past(loaded_count_r) + LCW'(1))
    else $error("fill count not advanced on write");

  // a query scan only reads loaded entries
  a_query_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUERY) && more_r |-> (scan_ptr_r <= hi_r) && (scan_ptr_r < loaded_ext))
    else $error("query scan outside loaded span");

endmodule

// ----- verif/tb_range_distinct_count_top.sv -----
`timescale 1ns / 1ps

module tb_range_distinct_count_top;
  import rdc_pkg::*;

  localparam int unsigned DEPTH = 1024;
  // the one action code the package leaves unnamed, the block must ignore it
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 580;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned MAX_LINES = 40;

  // a command word waiting to be sent; drain holds it back until all answers are in
  typedef struct {
    rdc_in_t word;
    bit      drain;
  } pending_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rdc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rdc_out_t out_data;

  range_distinct_count_top #(
    .STORE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the store: values, nearest earlier equal position, fill level
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] shadow_val [DEPTH];
  int unsigned               shadow_prev [DEPTH];
  bit                        shadow_has_prev [DEPTH];
  int unsigned               shadow_len = 0;

  pending_word_t pending [$];
  rdc_out_t      answers_due [$];
  int unsigned   errors = 0;

  // works out the answer word for one accepted command and updates the shadow
  function automatic rdc_out_t distinct_answer(input rdc_in_t w);
    rdc_out_t    a;
    int unsigned k;
    int unsigned repeats;
    int unsigned lo;
    int unsigned hi;
    a = '0;
    a.status = ST_OK;
    lo = w.left_index;
    hi = w.right_index;
    repeats = 0;
    case (w.action)
      ACT_CLEAR: begin
        shadow_len = 0;
      end
      ACT_LOAD: begin
        if (shadow_len >= DEPTH) begin
          // store full: nothing changes
          a.status = ST_FULL;
        end else begin
          // scan back for the nearest equal value
          shadow_has_prev[shadow_len] = 1'b0;
          shadow_prev[shadow_len] = 0;
          k = shadow_len;
          while (k > 0 && !shadow_has_prev[shadow_len]) begin
            if (shadow_val[k-1] == w.value) begin
              shadow_has_prev[shadow_len] = 1'b1;
              shadow_prev[shadow_len] = k - 1;
            end
            k--;
          end
          shadow_val[shadow_len] = w.value;
          shadow_len++;
        end
      end
      ACT_QUERY: begin
        // right index not loaded wins over left above right
        if (hi >= shadow_len) begin
          a.status = ST_RANGE;
        end else if (lo <= hi) begin
          for (k = lo; k <= hi; k++) begin
            if (shadow_has_prev[k] && shadow_prev[k] >= lo) repeats++;
          end
          a.distinct_count = COUNT_W'(hi - lo + 1 - repeats);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_LINES) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers pending words, idles at random except in a quiet window
  // ---------------------------------------------------------------------------
  int unsigned tx_words = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        answers_due.insert(answers_due.size(), distinct_answer(in_data));
        tx_words++;
      end
      // a held word stays put until taken
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && !(pending[0].drain && answers_due.size() != 0) &&
            ((tx_words >= 300 && tx_words < 420) || $urandom_range(99) >= IDLE_PCT)) begin
          in_data <= pending[0].word;
          in_valid <= 1'b1;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, a quiet window, and two long hold-offs so that
  // the output register and the sequencer both fill and the input backs up
  // ---------------------------------------------------------------------------
  int unsigned rx_words = 0;
  int unsigned rx_hold = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_words <= rx_words + 1;
      if (rx_words + 1 == 40 || rx_words + 1 == 450) rx_hold <= HOLD_CYCLES;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end
    out_stall <= (rx_hold != 0) ||
                 (!(rx_words >= 250 && rx_words < 400) && $urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // checker: each taken result word against the oldest outstanding answer
  // ---------------------------------------------------------------------------
  rdc_out_t due;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", out_data));
      end else begin
        due = answers_due.pop_front();
        if (out_data.distinct_count !== due.distinct_count)
          report_mismatch($sformatf("distinct_count %0d, predicted %0d",
                                    out_data.distinct_count, due.distinct_count));
        if (out_data.status !== due.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_data.status, due.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus planning; plan_len follows the fill level the words will leave
  // ---------------------------------------------------------------------------
  int unsigned        plan_len = 0;
  logic [VALUE_W-1:0] pool [128];
  int unsigned        pool_n = 1;

  task automatic push_word(input logic [1:0] act, input logic [VALUE_W-1:0] val,
                           input int unsigned lo, input int unsigned hi, input bit drain);
    pending_word_t p;
    p.word.action = act;
    p.word.value = val;
    p.word.left_index = lo[INDEX_W-1:0];
    p.word.right_index = hi[INDEX_W-1:0];
    p.drain = drain;
    pending.insert(pending.size(), p);
    if (act == ACT_CLEAR) plan_len = 0;
    else if (act == ACT_LOAD && plan_len < DEPTH) plan_len++;
  endtask

  task automatic push_random_load();
    logic [VALUE_W-1:0] v;
    // mostly from a small pool so that repeats are common
    v = ($urandom_range(99) < 15) ? $urandom : pool[$urandom_range(pool_n - 1)];
    push_word(ACT_LOAD, v, $urandom_range(1023), $urandom_range(1023), 1'b0);
  endtask

  task automatic push_random_query();
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    pick = $urandom_range(99);
    if (plan_len == 0 || pick < 15) begin
      // right index at or past the fill level
      hi = $urandom_range(1023, plan_len);
      lo = $urandom_range(1023);
    end else if (pick < 25) begin
      // left above a loaded right
      hi = $urandom_range(plan_len - 1);
      lo = $urandom_range(1023, hi + 1);
    end else begin
      hi = $urandom_range(plan_len - 1);
      lo = $urandom_range(hi);
    end
    push_word(ACT_QUERY, $urandom, lo, hi, 1'b0);
  endtask

  initial begin
    int unsigned        i;
    int unsigned        sess;
    int unsigned        steps;
    int unsigned        pick;
    int unsigned        cap;
    int unsigned        rand_items;
    bit                 big;
    logic [VALUE_W-1:0] seed_val;

    // directed: extremes of value, every action, the query error cases
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);                 // empty store
    push_word(ACT_LOAD, 32'h8000_0000, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h7fff_ffff, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h8000_0000, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'hffff_ffff, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h0000_0000, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'hffff_ffff, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h7fff_ffff, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 6, 1'b0);                 // whole array
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 6, 6, 1'b0);
    push_word(ACT_QUERY, $urandom, 1, 5, 1'b0);
    push_word(ACT_QUERY, $urandom, 3, 1, 1'b0);                 // left above right
    push_word(ACT_QUERY, $urandom, 1023, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 7, 1'b0);                 // right just past the fill
    push_word(ACT_QUERY, $urandom, 0, 1023, 1'b0);
    push_word(ACT_SPARE, '1, 1023, 1023, 1'b0);
    push_word(ACT_QUERY, $urandom, 2, 6, 1'b0);
    push_word(ACT_CLEAR, $urandom, 1023, 1023, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);                 // nothing loaded after clear
    push_word(ACT_LOAD, 32'h7fff_ffff, 0, 0, 1'b0);             // old entries must not match
    push_word(ACT_LOAD, 32'h8000_0000, 0, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 1, 1'b0);

    // random sessions: a clear, then loads and queries on a short array;
    // one longer session puts equal values far apart
    rand_items = 0;
    sess = 0;
    while (rand_items < RANDOM_WORDS) begin
      big = (sess == 6);
      cap = big ? 300 : 60;
      pool_n = big ? 128 : $urandom_range(8, 2);
      for (i = 0; i < pool_n; i++)
        pool[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7) - 3;
      push_word(ACT_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023),
                sess == 0 || $urandom_range(3) == 0);
      steps = big ? 420 : $urandom_range(40, 10);
      for (i = 0; i < steps; i++) begin
        pick = $urandom_range(99);
        if (pick < 50 && plan_len < cap) push_random_load();
        else if (pick < 95) push_random_query();
        else if (pick < 98) push_word(ACT_SPARE, $urandom, $urandom_range(1023),
                                      $urandom_range(1023), 1'b0);
        else push_word(ACT_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023), 1'b0);
      end
      rand_items += steps + 1;
      sess++;
    end

    // one full fill with distinct values, then loads into the full store
    push_word(ACT_CLEAR, $urandom, 0, 0, 1'b1);
    seed_val = $urandom;
    for (i = 0; i < DEPTH; i++)
      push_word(ACT_LOAD, seed_val + i * 32'h9e37_79b1, $urandom_range(1023),
                $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h7fff_ffff, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_LOAD, 32'h8000_0000, $urandom_range(1023), $urandom_range(1023), 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 1023, 1'b0);              // widest count
    push_word(ACT_QUERY, $urandom, 1023, 1023, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 1023, 0, 1'b0);
    for (i = 0; i < 3; i++)
      push_word(ACT_QUERY, $urandom, $urandom_range(511), $urandom_range(1023, 512), 1'b0);
    push_word(ACT_CLEAR, $urandom, 0, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);
    push_word(ACT_LOAD, seed_val, 0, 0, 1'b0);
    push_word(ACT_QUERY, $urandom, 0, 0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to be sent and answered, then let stragglers show
    while (pending.size() != 0 || in_valid || answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit, several times the slowest legal run (dominated by the full fill)
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/range_distinct_count_top.sv
verif/tb_range_distinct_count_top.sv
